@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the grid map kernel splat design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, held off while reset is asserted.
`define GMKS_ASSERT(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define GMKS_ASSERT_ALWAYS(lbl, c, prop, msg) \
  lbl: assert property (@(posedge c) prop) else $error(msg);

`endif

@@ design/gmks_pkg.sv @@
// ----------------------------------------------------------------------------
// gmks_pkg
// Shared types, codes and the kernel table builder for the splat core.
// ----------------------------------------------------------------------------
`default_nettype none

package gmks_pkg;

  localparam int COORD_W    = 8;
  localparam int VAL_W      = 7;
  localparam int BND_W      = 9;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 8'd1;

  localparam logic OP_MARK = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [VAL_W-1:0] CELL_FULL = 7'd100;

  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = $clog2(Q_DEPTH);

  // Kernel table covers |dx|,|dy| up to 15.
  localparam int KT_SIDE = 16;
  localparam int KT_W    = KT_SIDE * KT_SIDE * VAL_W;

  typedef struct packed {
    logic                 op;
    logic                 oor;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [BND_W-1:0]     x_lo;
    logic [BND_W-1:0]     x_hi;
    logic [BND_W-1:0]     y_lo;
    logic [BND_W-1:0]     y_hi;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Largest v in 0..100 with 10000*(ax^2+ay^2) <= ((100-v)*radius)^2.
  function automatic logic [KT_W-1:0] kernel_table(input int radius);
    logic [KT_W-1:0] tab;
    longint          lhs;
    longint          t;
    int              k;
    tab = '0;
    for (int ay = 0; ay < KT_SIDE; ay++) begin
      for (int ax = 0; ax < KT_SIDE; ax++) begin
        lhs = 64'(10000 * (ax * ax + ay * ay));
        k   = 0;
        for (int v = 0; v <= 100; v++) begin
          t = 64'((100 - v) * radius);
          if (lhs <= t * t) begin
            k = v;
          end
        end
        tab[(ay * KT_SIDE + ax) * VAL_W +: VAL_W] = VAL_W'(k);
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

@@ design/gmks_channels.sv @@
// ----------------------------------------------------------------------------
// gmks channels
// Valid/ready channel interfaces for items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmks_in_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [gmks_pkg::COORD_W-1:0] cell_x;
  logic [gmks_pkg::COORD_W-1:0] cell_y;

  modport source (output valid, output opcode, output cell_x, output cell_y, input ready);
  modport sink   (input valid, input opcode, input cell_x, input cell_y, output ready);
endinterface

interface gmks_out_if;
  logic                       valid;
  logic                       ready;
  logic [gmks_pkg::VAL_W-1:0] cell_value;
  logic                       was_new;
  logic                       out_of_range;

  modport source (output valid, output cell_value, output was_new, output out_of_range,
                  input ready);
  modport sink   (input valid, input cell_value, input was_new, input out_of_range,
                  output ready);
endinterface

interface gmks_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gmks_pkg::CFG_IDX_W-1:0]  index;
  logic [gmks_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/grid_map_kernel_splat_core.sv @@
// ----------------------------------------------------------------------------
// grid_map_kernel_splat_core
// Likelihood grid map: marks splat a conical kernel, reads return one cell.
// ----------------------------------------------------------------------------
//  channel    dir  fields                                  transfer
//  in_chan    in   opcode, cell_x, cell_y                  valid & ready
//  out_chan   out  cell_value, was_new, out_of_range       valid & ready
//  cfg_chan   in   index, data (0 columns, 1 rows)         valid & ready
//
//  Back end states per item: IDLE, CHECK, SWEEP, RESP for a mark that splats
//  (SWEEP visits the clipped square, up to (2R+1)^2 = 121 cells at R=5),
//  IDLE, CHECK, RESP for a read or a mark on a full cell, IDLE, RESP out of range.
//  After reset a clear pass zeroes all MAX_WIDTH*MAX_HEIGHT cells (65536) of
//  the grid; in_chan.ready stays low during it, cfg writes are taken.
//  A two-entry queue keeps accepting while a result waits on out_chan.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grid_map_kernel_splat_core #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int SPLAT_RADIUS = 5
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gmks_in_if.sink     in_chan,
  gmks_out_if.source  out_chan,
  gmks_cfg_if.sink    cfg_chan
);

  logic               clearing;
  logic               q_push;
  logic               q_pop;
  gmks_pkg::cmd_t     q_push_cmd;
  gmks_pkg::cmd_t     q_head;
  gmks_pkg::q_stat_t  q_stat;

  gmks_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .SPLAT_RADIUS (SPLAT_RADIUS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cfg_chan (cfg_chan),
    .clearing (clearing),
    .q_stat   (q_stat),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  gmks_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  gmks_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .SPLAT_RADIUS (SPLAT_RADIUS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .head     (q_head),
    .pop      (q_pop),
    .clearing (clearing),
    .out_chan (out_chan)
  );

  `GMKS_ASSERT(a_no_accept_in_clear, clk, rst_n, clearing |-> !in_chan.ready, "taken in clear")
  `GMKS_ASSERT(a_no_q_overflow, clk, rst_n, q_push |-> !q_stat.full, "push into full queue")
  `GMKS_ASSERT(a_q_empty_clr, clk, rst_n, $fell(clearing) |-> q_stat.empty, "queue busy")

endmodule

`default_nettype wire

@@ design/gmks_queue.sv @@
// ----------------------------------------------------------------------------
// gmks_queue
// Short command FIFO between the classifier front and the grid back end.
// ----------------------------------------------------------------------------
`default_nettype none

module gmks_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gmks_pkg::cmd_t     push_cmd,
  input  wire logic               pop,
  output gmks_pkg::cmd_t          head,
  output gmks_pkg::q_stat_t       stat
);

  localparam int PW = gmks_pkg::Q_PW;
  localparam int CW = gmks_pkg::Q_PW + 1;

  gmks_pkg::cmd_t   slot_r [gmks_pkg::Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CW'(gmks_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

`default_nettype wire

@@ design/gmks_front.sv @@
// ----------------------------------------------------------------------------
// gmks_front
// Map size registers; range check and clipped kernel bounds per item.
// ----------------------------------------------------------------------------
`default_nettype none

module gmks_front #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int SPLAT_RADIUS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  gmks_in_if.sink             in_chan,
  gmks_cfg_if.sink            cfg_chan,
  input  wire logic           clearing,
  input  wire gmks_pkg::q_stat_t q_stat,
  output logic                push,
  output gmks_pkg::cmd_t      push_cmd
);

  localparam int BW = gmks_pkg::BND_W;
  localparam logic [BW-1:0] W_RST  = (MAX_WIDTH < 256) ? BW'(MAX_WIDTH) : 9'd256;
  localparam logic [BW-1:0] H_RST  = (MAX_HEIGHT < 256) ? BW'(MAX_HEIGHT) : 9'd256;
  localparam logic [BW-1:0] RAD    = BW'(SPLAT_RADIUS);

  logic [BW-1:0] map_w_r;
  logic [BW-1:0] map_h_r;
  logic [BW-1:0] xe;
  logic [BW-1:0] ye;
  logic [BW-1:0] x_top;
  logic [BW-1:0] y_top;

  function automatic logic [BW-1:0] clamp_size(input logic [BW-1:0] v, input int max);
    if (v == '0) begin
      return BW'(1);
    end
    if (int'(v) > max) begin
      return BW'(max);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_w_r <= W_RST;
      map_h_r <= H_RST;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        gmks_pkg::REG_GRID_COLS: map_w_r <= clamp_size(cfg_chan.data, MAX_WIDTH);
        gmks_pkg::REG_GRID_ROWS: map_h_r <= clamp_size(cfg_chan.data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = !clearing && !q_stat.full;
  assign push           = in_chan.valid && in_chan.ready;

  assign xe    = {1'b0, in_chan.cell_x};
  assign ye    = {1'b0, in_chan.cell_y};
  assign x_top = xe + RAD;
  assign y_top = ye + RAD;

  always_comb begin
    push_cmd.op   = in_chan.opcode;
    push_cmd.oor  = (xe >= map_w_r) || (ye >= map_h_r);
    push_cmd.cx   = in_chan.cell_x;
    push_cmd.cy   = in_chan.cell_y;
    push_cmd.x_lo = (xe > RAD) ? (xe - RAD) : '0;
    push_cmd.y_lo = (ye > RAD) ? (ye - RAD) : '0;
    push_cmd.x_hi = (x_top < map_w_r) ? x_top : (map_w_r - BW'(1));
    push_cmd.y_hi = (y_top < map_h_r) ? y_top : (map_h_r - BW'(1));
  end

endmodule

`default_nettype wire

@@ design/gmks_back.sv @@
// ----------------------------------------------------------------------------
// gmks_back
// Grid memory, clear sweep after reset, kernel splat sequencer, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module gmks_back #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int SPLAT_RADIUS = 5
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire gmks_pkg::q_stat_t q_stat,
  input  wire gmks_pkg::cmd_t head,
  output logic                pop,
  output logic                clearing,
  gmks_out_if.source          out_chan
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = gmks_pkg::VAL_W;
  localparam int BW    = gmks_pkg::BND_W;
  localparam logic [gmks_pkg::KT_W-1:0] KTAB = gmks_pkg::kernel_table(SPLAT_RADIUS);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CHECK = 5'b00100,
    S_SWEEP = 5'b01000,
    S_RESP  = 5'b10000
  } state_t;

  logic [VW-1:0] mem [DEPTH];

  state_t          state_r,     state_nxt;
  logic [AW-1:0]   clr_cnt_r,   clr_cnt_nxt;
  logic            iss_done_r,  iss_done_nxt;
  logic            pend_r,      pend_nxt;
  logic            out_vld_r,   out_vld_nxt;
  gmks_pkg::cmd_t  cmd_r,       cmd_nxt;
  logic [BW-1:0]   xx_r,        xx_nxt;
  logic [BW-1:0]   yy_r,        yy_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic [VW-1:0]   pend_k_r,    pend_k_nxt;
  logic [VW-1:0]   res_val_r,   res_val_nxt;
  logic            res_new_r,   res_new_nxt;
  logic            res_oor_r,   res_oor_nxt;
  logic [VW-1:0]   out_val_r,   out_val_nxt;
  logic            out_new_r,   out_new_nxt;
  logic            out_oor_r,   out_oor_nxt;
  logic [VW-1:0]   rdata_r;

  logic            mem_we;
  logic            mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [AW-1:0]   mem_raddr;
  logic [VW-1:0]   mem_wdata;
  logic [AW-1:0]   cur_addr;
  logic [BW-1:0]   cxe;
  logic [BW-1:0]   cye;
  logic [BW-1:0]   adx;
  logic [BW-1:0]   ady;
  logic [7:0]      kidx;
  logic [VW-1:0]   kval;

  function automatic logic [AW-1:0] cell_addr(input logic [BW-1:0] x, input logic [BW-1:0] y);
    logic [31:0] a;
    a = 32'(y) * 32'(MAX_WIDTH) + 32'(x);
    return a[AW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  assign cxe      = {1'b0, cmd_r.cx};
  assign cye      = {1'b0, cmd_r.cy};
  assign adx      = (xx_r >= cxe) ? (xx_r - cxe) : (cxe - xx_r);
  assign ady      = (yy_r >= cye) ? (yy_r - cye) : (cye - yy_r);
  assign kidx     = {ady[3:0], adx[3:0]};
  assign kval     = KTAB[int'(kidx) * VW +: VW];
  assign cur_addr = cell_addr(xx_r, yy_r);
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    iss_done_nxt  = iss_done_r;
    pend_nxt      = pend_r;
    cmd_nxt       = cmd_r;
    xx_nxt        = xx_r;
    yy_nxt        = yy_r;
    pend_addr_nxt = pend_addr_r;
    pend_k_nxt    = pend_k_r;
    res_val_nxt   = res_val_r;
    res_new_nxt   = res_new_r;
    res_oor_nxt   = res_oor_r;
    out_val_nxt   = out_val_r;
    out_new_nxt   = out_new_r;
    out_oor_nxt   = out_oor_r;
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = pend_k_r;
    mem_raddr     = cur_addr;
    pop           = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = head;
          if (head.oor) begin
            res_val_nxt = '0;
            res_new_nxt = 1'b0;
            res_oor_nxt = 1'b1;
            state_nxt   = S_RESP;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cell_addr({1'b0, head.cx}, {1'b0, head.cy});
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (cmd_r.op == gmks_pkg::OP_READ || rdata_r == gmks_pkg::CELL_FULL) begin
          res_val_nxt = rdata_r;
          res_new_nxt = 1'b0;
          res_oor_nxt = 1'b0;
          state_nxt   = S_RESP;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = cell_addr(cxe, cye);
          mem_wdata    = gmks_pkg::CELL_FULL;
          xx_nxt       = cmd_r.x_lo;
          yy_nxt       = cmd_r.y_lo;
          iss_done_nxt = 1'b0;
          pend_nxt     = 1'b0;
          state_nxt    = S_SWEEP;
        end
      end
      S_SWEEP: begin
        // retire the cell read last cycle; the centre reads back full and is skipped
        if (pend_r && rdata_r != gmks_pkg::CELL_FULL && pend_k_r > rdata_r) begin
          mem_we = 1'b1;
        end
        if (iss_done_r) begin
          pend_nxt    = 1'b0;
          res_val_nxt = gmks_pkg::CELL_FULL;
          res_new_nxt = 1'b1;
          res_oor_nxt = 1'b0;
          state_nxt   = S_RESP;
        end else begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = cur_addr;
          pend_k_nxt    = kval;
          if (xx_r == cmd_r.x_hi) begin
            xx_nxt = cmd_r.x_lo;
            if (yy_r == cmd_r.y_hi) begin
              iss_done_nxt = 1'b1;
            end else begin
              yy_nxt = yy_r + BW'(1);
            end
          end else begin
            xx_nxt = xx_r + BW'(1);
          end
        end
      end
      S_RESP: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt = 1'b1;
          out_val_nxt = res_val_r;
          out_new_nxt = res_new_r;
          out_oor_nxt = res_oor_r;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      iss_done_r <= 1'b0;
      pend_r     <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      iss_done_r <= iss_done_nxt;
      pend_r     <= pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    xx_r        <= xx_nxt;
    yy_r        <= yy_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_k_r    <= pend_k_nxt;
    res_val_r   <= res_val_nxt;
    res_new_r   <= res_new_nxt;
    res_oor_r   <= res_oor_nxt;
    out_val_r   <= out_val_nxt;
    out_new_r   <= out_new_nxt;
    out_oor_r   <= out_oor_nxt;
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.cell_value   = out_val_r;
  assign out_chan.was_new      = out_new_r;
  assign out_chan.out_of_range = out_oor_r;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for grid_map_kernel_splat_core. A local grid model
// follows every accepted mark and read and queues the cell result each one
// should return. Directed corner cases come first, then size-limit register
// writes, then clustered random traffic on several map shapes, with bursty
// input and a stalling result sink.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int GRID_W      = 256;
  localparam int GRID_H      = 256;
  localparam int RADIUS      = 5;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 130;
  localparam int QUIET_CYCLES = 8;

  localparam logic [gmks_pkg::CFG_IDX_W-1:0] REG_SPARE    = 8'd2;
  localparam logic [gmks_pkg::CFG_IDX_W-1:0] REG_TOP_SLOT = 8'hFF;

  typedef struct packed {
    logic [gmks_pkg::VAL_W-1:0] value;
    logic                       fresh;
    logic                       oor;
  } cell_result_t;

  typedef enum logic [1:0] {SINK_FREE, SINK_COIN, SINK_HOLD, SINK_THIRD} sink_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic sink_ready = 1'b0;

  gmks_in_if  in_chan ();
  gmks_out_if out_chan ();
  gmks_cfg_if cfg_chan ();

  assign out_chan.ready = sink_ready;

  grid_map_kernel_splat_core #(
    .MAX_WIDTH    (GRID_W),
    .MAX_HEIGHT   (GRID_H),
    .SPLAT_RADIUS (RADIUS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // grid model
  logic [gmks_pkg::VAL_W-1:0] grid [0:GRID_W*GRID_H-1];
  logic [gmks_pkg::VAL_W-1:0] cone [0:RADIUS][0:RADIUS];
  int               cols = GRID_W;
  int               rows = GRID_H;
  cell_result_t     cell_results_due [$];

  int mismatches = 0;
  int cycles     = 0;
  int burst_left = 0;

  function automatic int cone_level(input int ax, input int ay);
    int reach;
    int v;
    reach = 10000 * (ax * ax + ay * ay);
    v = 100;
    while (v > 0 && reach > ((100 - v) * RADIUS) * ((100 - v) * RADIUS)) v--;
    return v;
  endfunction

  function automatic int fit_size(input logic [gmks_pkg::CFG_DATA_W-1:0] v, input int limit);
    if (v == 0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  function automatic void load_reg(input logic [gmks_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [gmks_pkg::CFG_DATA_W-1:0] v);
    case (idx)
      gmks_pkg::REG_GRID_COLS: cols = fit_size(v, GRID_W);
      gmks_pkg::REG_GRID_ROWS: rows = fit_size(v, GRID_H);
      default: ;
    endcase
  endfunction

  function automatic cell_result_t apply_grid_op(input logic op,
                                                 input logic [gmks_pkg::COORD_W-1:0] x,
                                                 input logic [gmks_pkg::COORD_W-1:0] y);
    cell_result_t r;
    int xi, yi, base, a;
    int xs, xe, ys, ye;
    int ax, ay;
    r = '0;
    xi = int'(x);
    yi = int'(y);
    if (xi >= cols || yi >= rows) begin
      r.oor = 1'b1;
      return r;
    end
    base = yi * GRID_W + xi;
    if (op == gmks_pkg::OP_MARK && grid[base] != gmks_pkg::CELL_FULL) begin
      grid[base] = gmks_pkg::CELL_FULL;
      xs = (xi < RADIUS) ? -xi : -RADIUS;
      ys = (yi < RADIUS) ? -yi : -RADIUS;
      xe = (cols - 1 - xi < RADIUS) ? cols - 1 - xi : RADIUS;
      ye = (rows - 1 - yi < RADIUS) ? rows - 1 - yi : RADIUS;
      for (int dy = ys; dy <= ye; dy++) begin
        for (int dx = xs; dx <= xe; dx++) begin
          if (dx != 0 || dy != 0) begin
            a  = (yi + dy) * GRID_W + xi + dx;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            if (grid[a] != gmks_pkg::CELL_FULL && cone[ay][ax] > grid[a])
              grid[a] = cone[ay][ax];
          end
        end
      end
      r.fresh = 1'b1;
    end
    r.value = grid[base];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // result checker
  cell_result_t head;
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && sink_ready) begin
      if (cell_results_due.size() == 0) begin
        flag_mismatch("result with nothing pending", out_chan.cell_value, 0);
      end else begin
        head = cell_results_due.pop_front();
        if (out_chan.cell_value !== head.value)
          flag_mismatch("cell_value", out_chan.cell_value, head.value);
        if (out_chan.was_new !== head.fresh)
          flag_mismatch("was_new", out_chan.was_new, head.fresh);
        if (out_chan.out_of_range !== head.oor)
          flag_mismatch("out_of_range", out_chan.out_of_range, head.oor);
      end
    end
  end

  // result sink stall pattern
  sink_mode_t sink_mode = SINK_FREE;
  int         sink_left = 0;
  always @(posedge clk) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_t'($urandom_range(0, 3));
      sink_left = $urandom_range(4, 60);
    end
    sink_left--;
    case (sink_mode)
      SINK_FREE:  sink_ready <= 1'b1;
      SINK_COIN:  sink_ready <= 1'($urandom_range(0, 1));
      SINK_HOLD:  sink_ready <= 1'b0;
      default:    sink_ready <= (sink_left % 3 == 0);
    endcase
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** grid_map_kernel_splat_core: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [gmks_pkg::COORD_W-1:0] x,
                           input logic [gmks_pkg::COORD_W-1:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_chan.valid  <= 1'b1;
    in_chan.opcode <= op;
    in_chan.cell_x <= x;
    in_chan.cell_y <= y;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    cell_results_due.push_back(apply_grid_op(op, x, y));
    burst_left--;
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    while (cell_results_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // leaves valid high for back-to-back writes; the caller drops it after the last one
  task automatic write_reg(input logic [gmks_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gmks_pkg::CFG_DATA_W-1:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= v;
    @(posedge clk);
    while (cfg_chan.ready !== 1'b1) @(posedge clk);
    load_reg(idx, v);
  endtask

  task automatic set_map(input logic [gmks_pkg::CFG_DATA_W-1:0] w,
                         input logic [gmks_pkg::CFG_DATA_W-1:0] h);
    write_reg(gmks_pkg::REG_GRID_COLS, w);
    write_reg(gmks_pkg::REG_GRID_ROWS, h);
    cfg_chan.valid <= 1'b0;
  endtask

  task automatic random_items(input int count);
    int ax, ay, x, y, pick;
    logic op;
    ax = 0;
    ay = 0;
    for (int i = 0; i < count; i++) begin
      if (i == 0 || $urandom_range(0, 9) == 0) begin
        ax = $urandom_range(0, cols - 1);
        ay = $urandom_range(0, rows - 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        x = ax + $urandom_range(0, 12) - 6;
        y = ay + $urandom_range(0, 12) - 6;
      end else if (pick < 95) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else begin
        x = cols + $urandom_range(0, 3);
        y = $urandom_range(0, rows);
      end
      op = ($urandom_range(0, 99) < 45) ? gmks_pkg::OP_MARK : gmks_pkg::OP_READ;
      send_item(op, gmks_pkg::COORD_W'(x), gmks_pkg::COORD_W'(y));
    end
  endtask

  task automatic test_directed_marks();
    send_item(gmks_pkg::OP_READ, 8'd0, 8'd0);
    send_item(gmks_pkg::OP_MARK, 8'd0, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd1, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd0, 8'd1);
    send_item(gmks_pkg::OP_READ, 8'd1, 8'd1);
    send_item(gmks_pkg::OP_READ, 8'd5, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd4, 8'd3);
    send_item(gmks_pkg::OP_READ, 8'd5, 8'd5);
    send_item(gmks_pkg::OP_MARK, 8'd0, 8'd0);
    send_item(gmks_pkg::OP_MARK, 8'd2, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd1, 8'd0);
    send_item(gmks_pkg::OP_MARK, 8'd255, 8'd255);
    send_item(gmks_pkg::OP_READ, 8'd255, 8'd255);
    send_item(gmks_pkg::OP_READ, 8'd250, 8'd255);
    send_item(gmks_pkg::OP_READ, 8'd254, 8'd254);
    send_item(gmks_pkg::OP_MARK, 8'd128, 8'd128);
    send_item(gmks_pkg::OP_MARK, 8'd128, 8'd131);
    send_item(gmks_pkg::OP_READ, 8'd128, 8'd130);
    send_item(gmks_pkg::OP_READ, 8'd133, 8'd128);
    send_item(gmks_pkg::OP_READ, 8'd129, 8'd129);
    send_item(gmks_pkg::OP_MARK, 8'd255, 8'd0);
    send_item(gmks_pkg::OP_MARK, 8'd0, 8'd255);
    send_item(gmks_pkg::OP_READ, 8'd3, 8'd252);
    settle();
  endtask

  task automatic test_size_limits();
    set_map(9'd0, 9'd0);
    send_item(gmks_pkg::OP_MARK, 8'd0, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd0, 8'd0);
    send_item(gmks_pkg::OP_MARK, 8'd1, 8'd0);
    send_item(gmks_pkg::OP_READ, 8'd0, 8'd1);
    send_item(gmks_pkg::OP_MARK, 8'd255, 8'd255);
    settle();
    write_reg(REG_SPARE, 9'h155);
    write_reg(REG_TOP_SLOT, 9'h0AA);
    cfg_chan.valid <= 1'b0;
    send_item(gmks_pkg::OP_READ, 8'd0, 8'd1);
    settle();
    set_map(9'd511, 9'd511);
    send_item(gmks_pkg::OP_READ, 8'd255, 8'd255);
    send_item(gmks_pkg::OP_MARK, 8'd200, 8'd3);
    settle();
    set_map(9'd300, 9'd257);
    send_item(gmks_pkg::OP_READ, 8'd201, 8'd4);
    settle();
    set_map(9'd256, 9'd256);
    send_item(gmks_pkg::OP_READ, 8'd255, 8'd250);
    settle();
  endtask

  task automatic test_random_maps();
    set_map(9'd16, 9'd16);
    random_items(260);
    settle();
    set_map(9'd1, 9'd256);
    random_items(120);
    settle();
    set_map(9'd256, 9'd1);
    random_items(120);
    settle();
    set_map(9'd13, 9'd7);
    random_items(160);
    settle();
    repeat (3) begin
      set_map(gmks_pkg::CFG_DATA_W'($urandom_range(1, 511)),
              gmks_pkg::CFG_DATA_W'($urandom_range(1, 511)));
      random_items(150);
      settle();
    end
  endtask

  task automatic test_full_map();
    set_map(9'd256, 9'd256);
    random_items(380);
    settle();
    random_items(380);
    settle();
  endtask

  initial begin
    for (int ay = 0; ay <= RADIUS; ay++)
      for (int ax = 0; ax <= RADIUS; ax++)
        cone[ay][ax] = gmks_pkg::VAL_W'(cone_level(ax, ay));
    for (int i = 0; i < GRID_W * GRID_H; i++) grid[i] = '0;

    rst_n           <= 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.opcode  <= gmks_pkg::OP_READ;
    in_chan.cell_x  <= '0;
    in_chan.cell_y  <= '0;
    cfg_chan.valid  <= 1'b0;
    cfg_chan.index  <= gmks_pkg::REG_GRID_COLS;
    cfg_chan.data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_marks();
    test_size_limits();
    test_random_maps();
    test_full_map();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cell_results_due.size() != 0)
      flag_mismatch("results never returned", 0, cell_results_due.size());
    if (mismatches == 0) begin
      $display("** grid_map_kernel_splat_core: PASSED **");
    end else begin
      $display("** grid_map_kernel_splat_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ grid_map_kernel_splat_core.f @@
+incdir+design
design/gmks_pkg.sv
design/gmks_channels.sv
design/gmks_queue.sv
design/gmks_front.sv
design/gmks_back.sv
design/grid_map_kernel_splat_core.sv
bench/tb_top.sv
